// ===== sv/bba_pkg.sv =====
// Package for the block bump allocator: item structs, field widths and codes.
// Used by every module of the allocator except bba_ram; depends on nothing.
package bba_pkg;

   localparam int OFF_W    = 30;
   localparam int SIZE_W   = 24;
   localparam int ALIGN_W  = 5;
   localparam int LG_W     = 5;
   localparam int COUNT_W  = 25;
   localparam int STATUS_W = 2;

   // Usable range and reset value of the block size register.
   localparam logic [LG_W-1:0] LG_MIN   = 5'd4;
   localparam logic [LG_W-1:0] LG_MAX   = 5'd24;
   localparam logic [LG_W-1:0] LG_RESET = 5'd16;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

   typedef struct packed {
      logic               operation;
      logic [SIZE_W-1:0]  size;
      logic [ALIGN_W-1:0] align_log2;
      logic [OFF_W-1:0]   offset;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFF_W-1:0]    offset_out;
   } rsp_item_type;

   // Commands from the allocation logic to the free block stack.
   typedef struct packed {
      logic pop;
      logic push;
   } stack_cmd_type;

endpackage

// ===== sv/bba_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bba_free_stack.sv =====
// LIFO stack of free block indexes for the block bump allocator.
// Depends on bba_pkg and bba_ram.
module bba_free_stack import bba_pkg::*; #(
   parameter int NUM_BLOCKS = 64,
   localparam int IDX_W = $clog2(NUM_BLOCKS),
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  stack_cmd_type cmd,
   input  logic [IDX_W-1:0] push_idx,
   output logic [IDX_W-1:0] top_idx,
   output logic          empty,
   output logic [CNT_W-1:0] fresh_count
);

   localparam logic [CNT_W-1:0] FULL = CNT_W'(NUM_BLOCKS);

   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0] low_ff, low_in;
   logic             fwd_vld_ff;
   logic [IDX_W-1:0] fwd_idx_ff;
   logic             do_push;
   logic [CNT_W-1:0] rd_pos;
   logic [CNT_W-1:0] virgin_val;
   logic [IDX_W-1:0] ram_q;

   // The low-water mark tells which positions still hold their reset
   // contents: while the depth sits at the mark, the top has never been
   // overwritten, and the first pops hand out blocks 0, 1, 2 and so on.
   assign do_push = cmd.push && (depth_ff != FULL);

   always_comb begin
      depth_in = depth_ff;
      priority if (cmd.pop && (depth_ff != '0)) begin
         depth_in = depth_ff - CNT_W'(1);
      end else if (do_push) begin
         depth_in = depth_ff + CNT_W'(1);
      end
      low_in = (depth_in < low_ff) ? depth_in : low_ff;
   end

   // The read port always fetches the top of the next cycle.
   assign rd_pos     = depth_in - CNT_W'(1);
   assign virgin_val = FULL - depth_ff;

   bba_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_BLOCKS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (depth_ff[IDX_W-1:0]),
      .wr_data (push_idx),
      .rd_en   (1'b1),
      .rd_addr (rd_pos[IDX_W-1:0]),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= FULL;
         low_ff     <= FULL;
         fwd_vld_ff <= 1'b0;
      end else begin
         depth_ff   <= depth_in;
         low_ff     <= low_in;
         fwd_vld_ff <= do_push;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fwd_idx_ff <= push_idx;
      end
   end

   always_comb begin
      if (depth_ff == low_ff) begin
         top_idx = virgin_val[IDX_W-1:0];
      end else if (fwd_vld_ff) begin
         top_idx = fwd_idx_ff;
      end else begin
         top_idx = ram_q;
      end
   end

   assign empty       = (depth_ff == '0);
   assign fresh_count = FULL - low_ff;

endmodule

// ===== sv/bba_count_store.sv =====
// Live allocation counts per block, held in a RAM with write forwarding.
// Depends on bba_pkg and bba_ram.
module bba_count_store import bba_pkg::*; #(
   parameter int NUM_BLOCKS = 64,
   localparam int IDX_W = $clog2(NUM_BLOCKS),
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [COUNT_W-1:0] wr_data,
   input  logic [IDX_W-1:0]   chk_addr,
   input  logic [CNT_W-1:0]   fresh_count,
   output logic [COUNT_W-1:0] count
);

   logic               fwd_vld_ff;
   logic [COUNT_W-1:0] fwd_data_ff;
   logic [COUNT_W-1:0] ram_q;

   bba_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_BLOCKS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // A write landing on the address read in the same cycle is captured here.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_vld_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   // Blocks never handed out by the stack have never been written and count zero.
   always_comb begin
      if (fwd_vld_ff) begin
         count = fwd_data_ff;
      end else if (CNT_W'(chk_addr) < fresh_count) begin
         count = ram_q;
      end else begin
         count = '0;
      end
   end

endmodule

// ===== sv/block_bump_allocator_core.sv =====
// Block bump allocator: accepted items and their results are held in registers.
// One item per cycle unless the result side stalls: one processing stage between
// input and result registers, with forwarding around the count and stack RAMs.
// Reset (synchronous): all blocks free, no current block, block size 2^16.
// No clearing pass: the stack and count RAMs are tracked by a low-water mark.
// Depends on bba_pkg, bba_ram, bba_free_stack and bba_count_store.
module block_bump_allocator_core import bba_pkg::*; #(
   parameter int NUM_BLOCKS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_item_type    req_item,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_item_type    rsp_item,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [LG_W-1:0] csr_data
);

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   // Absolute offsets plus room for alignment and size overshoot past the end.
   localparam int FILL_W = IDX_W + SIZE_W + 2;
   localparam int EXT_W  = (FILL_W > OFF_W) ? FILL_W : OFF_W;

   // Configuration and handshake state.
   logic [LG_W-1:0]    lg_cfg_ff;
   logic               in_vld_ff, in_vld_in;
   req_item_type       in_item_ff;
   logic [IDX_W-1:0]   blk_idx_ff, blk_idx_in;
   logic               blk_oor_ff, blk_oor_in;
   logic               out_vld_ff, out_vld_in;
   rsp_item_type       out_item_ff, out_item_in;

   // Current block state.
   logic               cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0]   cur_idx_ff, cur_idx_in;
   logic [FILL_W-1:0]  cur_fill_ff, cur_fill_in;
   logic [COUNT_W-1:0] cur_count_ff, cur_count_in;

   logic               fire;
   logic               accept;
   logic [LG_W-1:0]    lg_eff;
   logic [OFF_W-1:0]   blk_pos;

   // Allocation datapath.
   logic [COUNT_W-1:0] bsize;
   logic               reject;
   logic [FILL_W-1:0]  align_mask;
   logic [FILL_W-1:0]  cur_start;
   logic [FILL_W-1:0]  cur_next;
   logic [FILL_W-1:0]  cur_end;
   logic               fits;
   logic [FILL_W-1:0]  pop_start;
   logic [FILL_W-1:0]  alloc_start;
   logic [EXT_W-1:0]   start_ext;

   // Free datapath.
   logic [COUNT_W-1:0] free_count;
   logic [COUNT_W-1:0] free_dec;
   logic               free_bad;
   logic               free_is_cur;

   // Sub-block connections.
   stack_cmd_type      stk_cmd;
   logic [IDX_W-1:0]   stk_top;
   logic               stk_empty;
   logic [CNT_W-1:0]   fresh_count;
   logic               cnt_wr_en;
   logic [IDX_W-1:0]   cnt_wr_addr;
   logic [COUNT_W-1:0] cnt_wr_data;

   // Write the register only while the block is idle; unchecked, so always ready.
   assign csr_ready = 1'b1;

   // An item moves from the input register to the result register whenever the
   // result register is empty or its item is being taken in this cycle, so a
   // new item is accepted every cycle while the result side keeps up.
   assign fire      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_item_ff;

   // Out-of-range block sizes are clamped to the usable range.
   always_comb begin
      if (lg_cfg_ff < LG_MIN) begin
         lg_eff = LG_MIN;
      end else if (lg_cfg_ff > LG_MAX) begin
         lg_eff = LG_MAX;
      end else begin
         lg_eff = lg_cfg_ff;
      end
   end

   // The block an incoming free points at is found on acceptance, so that its
   // live count can be read from RAM while the item sits in the input register.
   assign blk_pos    = req_item.offset >> lg_eff;
   assign blk_oor_in = (blk_pos >= OFF_W'(NUM_BLOCKS));
   assign blk_idx_in = blk_pos[IDX_W-1:0];

   // Allocation: try the current block first, else the block on top of the
   // stack. A freshly popped block starts at its base, which already meets any
   // alignment that is not larger than the block.
   assign bsize       = COUNT_W'(1) << lg_eff;
   assign reject      = (in_item_ff.size == '0) ||
                        ({1'b0, in_item_ff.size} >= bsize) ||
                        (in_item_ff.align_log2 > lg_eff);
   assign align_mask  = (FILL_W'(1) << in_item_ff.align_log2) - FILL_W'(1);
   assign cur_start   = (cur_fill_ff + align_mask) & ~align_mask;
   assign cur_next    = cur_start + FILL_W'(in_item_ff.size);
   assign cur_end     = (FILL_W'(cur_idx_ff) + FILL_W'(1)) << lg_eff;
   assign fits        = cur_valid_ff && (cur_next <= cur_end);
   assign pop_start   = FILL_W'(stk_top) << lg_eff;
   assign alloc_start = fits ? cur_start : pop_start;
   assign start_ext   = EXT_W'(alloc_start);

   // Free: drop one live allocation; the block goes back on the stack when
   // its count reaches zero.
   assign free_dec    = free_count - COUNT_W'(1);
   assign free_bad    = blk_oor_ff || (free_count == '0);
   assign free_is_cur = cur_valid_ff && (cur_idx_ff == blk_idx_ff);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_idx_in   = cur_idx_ff;
      cur_fill_in  = cur_fill_ff;
      cur_count_in = cur_count_ff;
      stk_cmd      = '0;
      cnt_wr_en    = 1'b0;
      cnt_wr_addr  = blk_idx_ff;
      cnt_wr_data  = free_dec;
      out_item_in  = out_item_ff;

      if (fire) begin
         out_item_in.status     = ST_OK;
         out_item_in.offset_out = '0;
         unique case (in_item_ff.operation)
            OP_ALLOC: begin
               if (reject || (!fits && stk_empty)) begin
                  out_item_in.status = ST_NO_MEM;
               end else begin
                  out_item_in.offset_out = start_ext[OFF_W-1:0];
                  cur_valid_in = 1'b1;
                  cur_fill_in  = alloc_start + FILL_W'(in_item_ff.size);
                  cnt_wr_en    = 1'b1;
                  if (fits) begin
                     cur_count_in = cur_count_ff + COUNT_W'(1);
                     cnt_wr_addr  = cur_idx_ff;
                  end else begin
                     // A popped block is always empty, so it starts at one.
                     stk_cmd.pop  = 1'b1;
                     cur_idx_in   = stk_top;
                     cur_count_in = COUNT_W'(1);
                     cnt_wr_addr  = stk_top;
                  end
                  cnt_wr_data = cur_count_in;
               end
            end
            OP_FREE: begin
               if (free_bad) begin
                  out_item_in.status = ST_BAD_FREE;
               end else begin
                  cnt_wr_en = 1'b1;
                  if (free_is_cur) begin
                     cur_count_in = free_dec;
                  end
                  if (free_dec == '0) begin
                     stk_cmd.push = 1'b1;
                     if (free_is_cur) begin
                        cur_valid_in = 1'b0;
                     end
                  end
               end
            end
            default: begin
               out_item_in.status = ST_NO_MEM;
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end

      if (fire) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   bba_free_stack #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_free_stack (
      .clock       (clock),
      .reset       (reset),
      .cmd         (stk_cmd),
      .push_idx    (blk_idx_ff),
      .top_idx     (stk_top),
      .empty       (stk_empty),
      .fresh_count (fresh_count)
   );

   bba_count_store #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_count_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept),
      .rd_addr     (blk_idx_in),
      .wr_en       (cnt_wr_en),
      .wr_addr     (cnt_wr_addr),
      .wr_data     (cnt_wr_data),
      .chk_addr    (blk_idx_ff),
      .fresh_count (fresh_count),
      .count       (free_count)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         lg_cfg_ff    <= LG_RESET;
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         cur_valid_ff <= 1'b0;
         cur_idx_ff   <= '0;
         cur_count_ff <= '0;
      end else begin
         if (csr_valid) begin
            lg_cfg_ff <= csr_data;
         end
         in_vld_ff    <= in_vld_in;
         out_vld_ff   <= out_vld_in;
         cur_valid_ff <= cur_valid_in;
         cur_idx_ff   <= cur_idx_in;
         cur_count_ff <= cur_count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
         blk_idx_ff <= blk_idx_in;
         blk_oor_ff <= blk_oor_in;
      end
      out_item_ff <= out_item_in;
      cur_fill_ff <= cur_fill_in;
   end

endmodule

// ===== tb/block_bump_allocator_core_tb.sv =====
// Self-checking testbench for block_bump_allocator_core: directed corner cases, then
// randomized allocate/free traffic over several block sizes, each result checked in order.
// Depends on bba_pkg and the allocator RTL; needs no files or arguments.
`timescale 1ns / 1ps

module block_bump_allocator_core_tb;
   import bba_pkg::*;

   localparam int NUM_BLOCKS = 64;
   // Length of the one long receiver stall that lets the block back up.
   localparam int LONG_HOLD  = 80;

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_item_type       req_item  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_item_type       rsp_item;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [LG_W-1:0]    csr_data  = '0;

   // Items waiting to be offered, and the results the block still owes us.
   req_item_type       request_queue [$];
   rsp_item_type       awaited_results [$];
   // Offsets of allocations believed live; frees are drawn from here.
   logic [OFF_W-1:0]   live_offsets [$];
   int unsigned        fail_count = 0;
   bit                 long_hold_req = 1'b0;

   // Shadow of the allocator state, updated as each item is accepted.
   logic [LG_W-1:0]    size_log2_reg = LG_RESET;
   longint unsigned    block_next  [NUM_BLOCKS];
   logic [COUNT_W-1:0] block_live  [NUM_BLOCKS];
   int unsigned        spare_stack [NUM_BLOCKS];
   int unsigned        spare_depth;
   bit                 open_valid;
   int unsigned        open_block;

   block_bump_allocator_core #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A generous ceiling; a correct run finishes far inside it.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // The register holds any 5-bit value, but the block clamps it into the usable range.
   function automatic int unsigned active_log2();
      if (size_log2_reg < LG_MIN) return LG_MIN;
      if (size_log2_reg > LG_MAX) return LG_MAX;
      return size_log2_reg;
   endfunction

   function automatic longint unsigned round_up(longint unsigned v, int unsigned a);
      longint unsigned m;
      m = (64'd1 << a) - 1;
      return (v + m) & ~m;
   endfunction

   // Applies one item to the shadow state and returns the result the block must give.
   function automatic rsp_item_type run_allocator(req_item_type r);
      rsp_item_type    res;
      int unsigned     lg;
      int unsigned     idx;
      longint unsigned bsize;
      longint unsigned start;
      longint unsigned blk;
      bit              fits;
      lg             = active_log2();
      bsize          = 64'd1 << lg;
      res.status     = ST_OK;
      res.offset_out = '0;
      if (r.operation == OP_ALLOC) begin
         // Requests that no block could ever satisfy are refused with no state change.
         if (r.size == 0 || r.size >= bsize || r.align_log2 > lg) begin
            res.status = ST_NO_MEM;
            return res;
         end
         fits = open_valid &&
                (round_up(block_next[open_block], r.align_log2) + r.size <=
                 (open_block + 1) * bsize);
         if (fits) begin
            idx = open_block;
         end else begin
            // A new block is needed; the old current block, if any, is abandoned
            // and only comes back once all its allocations are freed.
            if (spare_depth == 0) begin
               res.status = ST_NO_MEM;
               return res;
            end
            spare_depth--;
            idx             = spare_stack[spare_depth];
            block_next[idx] = idx * bsize;
            open_valid      = 1'b1;
            open_block      = idx;
         end
         start           = round_up(block_next[idx], r.align_log2);
         block_next[idx] = start + r.size;
         block_live[idx] = block_live[idx] + 1'b1;
         res.offset_out  = start[OFF_W-1:0];
         live_offsets.push_back(res.offset_out);
      end else begin
         blk = r.offset >> lg;
         if (blk >= NUM_BLOCKS) begin
            res.status = ST_BAD_FREE;
            return res;
         end
         idx = blk;
         if (block_live[idx] == 0) begin
            res.status = ST_BAD_FREE;
            return res;
         end
         block_live[idx]--;
         if (block_live[idx] == 0) begin
            if (open_valid && open_block == idx) open_valid = 1'b0;
            if (spare_depth < NUM_BLOCKS) begin
               spare_stack[spare_depth] = idx;
               spare_depth++;
            end
         end
      end
      return res;
   endfunction

   // Request side: offers one queued item at a time and holds it until it is taken.
   // After each item a random gap is drawn; now and then a quiet run with no gaps
   // at all starts or ends.
   int unsigned send_gap   = 0;
   bit          send_quiet = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (request_queue.size() > 0) begin
            req_item  <= request_queue.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
            send_gap = send_quiet ? 0 : $urandom_range(0, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: after each result, ready may drop for a random stall. A request from the
   // stimulus process starts one long hold so the pipeline fills and stalls its input.
   int unsigned stall_left = 0;
   int unsigned hold_left  = 0;
   bit          rcv_quiet  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            if ($urandom_range(0, 31) == 0) rcv_quiet = !rcv_quiet;
            stall_left = rcv_quiet ? 0 : $urandom_range(0, 6);
            rsp_ready <= (stall_left == 0);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= (stall_left == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Predicts on every accepted item and compares every accepted result, in order.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (req_valid && req_ready) awaited_results.push_back(run_allocator(req_item));
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result item with no request outstanding: status %0d offset_out %0d",
                      rsp_item.status, rsp_item.offset_out);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                  fail_count++;
               end
               if (rsp_item.offset_out !== want.offset_out) begin
                  $error("offset_out: expected %0d, got %0d",
                         want.offset_out, rsp_item.offset_out);
                  fail_count++;
               end
            end
         end
      end
   end

   // Stimulus helpers. Items are queued on the falling edge so the driver never races
   // the queue; the queue is kept short so frees see up-to-date live offsets.
   task automatic push_item(input logic op, input longint unsigned sz,
                            input int unsigned al, input longint unsigned off);
      req_item_type r;
      @(negedge clock);
      while (request_queue.size() >= 2) @(negedge clock);
      r.operation  = op;
      r.size       = sz[SIZE_W-1:0];
      r.align_log2 = al[ALIGN_W-1:0];
      r.offset     = off[OFF_W-1:0];
      request_queue.push_back(r);
   endtask

   // The field an operation ignores is filled with random bits.
   task automatic push_alloc(input longint unsigned sz, input int unsigned al);
      push_item(OP_ALLOC, sz, al, $urandom);
   endtask

   task automatic push_free(input longint unsigned off);
      push_item(OP_FREE, $urandom, $urandom, off);
   endtask

   function automatic logic [OFF_W-1:0] take_live_offset();
      int unsigned      k;
      logic [OFF_W-1:0] o;
      k = $urandom_range(0, live_offsets.size() - 1);
      o = live_offsets[k];
      live_offsets.delete(k);
      return o;
   endfunction

   // Waits until nothing is queued, offered or owed, then lets the pipeline settle.
   task automatic await_idle();
      @(negedge clock);
      while (request_queue.size() != 0 || req_valid || awaited_results.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_block_size(input logic [LG_W-1:0] v);
      @(posedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_log2_reg = v;
   endtask

   // One random item. Most are well-formed: allocations sized for the current block
   // size, and frees of offsets that were really handed out. A few are pure noise.
   task automatic random_request(input int unsigned free_pct, input int unsigned big_pct);
      int unsigned      lg;
      int unsigned      roll;
      int unsigned      al;
      longint unsigned  bsize;
      longint unsigned  sz;
      longint unsigned  base;
      logic [OFF_W-1:0] o;
      lg    = active_log2();
      bsize = 64'd1 << lg;
      roll  = $urandom_range(0, 99);
      if (roll < 8) begin
         push_item($urandom_range(0, 1), $urandom, $urandom, $urandom);
      end else if (roll < 8 + free_pct && live_offsets.size() > 0) begin
         o    = take_live_offset();
         base = o;
         base = (base >> lg) << lg;
         case ($urandom_range(0, 9))
            0: begin
               // Anywhere in the populated range; the live allocation stays listed.
               push_free($urandom_range(0, (NUM_BLOCKS << lg) - 1));
               live_offsets.push_back(o);
            end
            1, 2: push_free(base + $urandom_range(0, bsize - 1));
            default: push_free(o);
         endcase
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < big_pct)
            sz = $urandom_range(bsize / 2, bsize - 1);
         else if (roll < big_pct + 5)
            sz = $urandom_range(0, 1) ? 0 : bsize + $urandom_range(0, 3);
         else
            sz = $urandom_range(1, (bsize >> 4) > 1 ? (bsize >> 4) : 1);
         roll = $urandom_range(0, 19);
         if (roll == 0)
            al = $urandom_range(lg + 1, 31);
         else if (roll < 4)
            al = $urandom_range(0, lg);
         else
            al = $urandom_range(0, lg < 4 ? lg : 4);
         push_alloc(sz, al);
      end
   endtask

   // One block-size setting: random traffic, then every remaining allocation is freed
   // so the next setting starts with all blocks back on the stack. Halfway through,
   // the receiver may take its long hold or the sender may pause until all is drained.
   task automatic run_phase(input logic [LG_W-1:0] lg_val, input int unsigned count,
                            input int unsigned free_pct, input int unsigned big_pct,
                            input bit hold_rx, input bit pause_tx);
      write_block_size(lg_val);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            if (hold_rx) long_hold_req = 1'b1;
            if (pause_tx) await_idle();
         end
         random_request(free_pct, big_pct);
      end
      await_idle();
      while (live_offsets.size() > 0) push_free(take_live_offset());
      await_idle();
   endtask

   initial begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         block_next[i]  = 0;
         block_live[i]  = '0;
         spare_stack[i] = NUM_BLOCKS - 1 - i;
      end
      spare_depth = NUM_BLOCKS;
      open_valid  = 1'b0;
      open_block  = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset block size of 64 KiB. Block 0 is popped first.
      push_alloc(1, 0);                // first pop, offset 0
      push_alloc(0, 0);                // zero size is refused
      push_alloc(24'hFF_FFFF, 0);      // largest size field, far too big
      push_alloc(65536, 0);            // exactly the block size is refused
      push_alloc(65535, 0);            // fills block 0 to its last byte
      push_alloc(3, 16);               // alignment equal to the block size, new block
      push_alloc(1, 17);               // alignment above the block size
      push_alloc(1, 31);               // largest alignment field
      push_alloc(100, 5);              // aligned bump inside the current block
      push_free(30'h3FFF_FFFF);        // far beyond the last block
      push_free(NUM_BLOCKS << 16);     // first offset past the last block
      push_free(63 << 16);             // a block that was never used
      push_free(0);
      push_free(1);                    // block 0 drains and goes back on the stack
      push_free(0);                    // block 0 now has nothing live
      push_alloc(65000, 0);            // still fits in the current block 1
      push_free(65536);
      push_free(65536 + 500);          // block 1 still has one live allocation
      push_alloc(60000, 0);            // does not fit, block 1 is abandoned and block 0 comes back
      push_free(0);
      push_free(65536);                // abandoned block 1 drains and returns
      await_idle();
      // Every directed allocation has been freed by hand.
      live_offsets.delete();

      // Clamped low value with mostly block-sized requests: the stack runs dry.
      run_phase(5'd0,  120, 10, 80, 1'b0, 1'b0);
      run_phase(5'd24, 100, 40, 10, 1'b1, 1'b0);
      run_phase(5'd31,  90, 40, 10, 1'b0, 1'b0);
      run_phase(5'd3,  100, 45, 40, 1'b0, 1'b1);
      run_phase(5'd10, 110, 40, 15, 1'b0, 1'b0);
      run_phase(5'd6,  100, 35, 30, 1'b0, 1'b0);
      run_phase(5'd16, 100, 40, 10, 1'b0, 1'b0);
      run_phase(5'd25,  60, 40, 20, 1'b0, 1'b0);

      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bba_free_stack.sv
sv/bba_count_store.sv
sv/block_bump_allocator_core.sv
tb/block_bump_allocator_core_tb.sv
